// ----- design/serial_command_frame_decoder_unit_assert.svh -----
// assertion macros shared by the serial command frame decoder modules
// expects signals named clk and rst_n in the module that uses them
`ifndef SERIAL_COMMAND_FRAME_DECODER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfd assertion failed");

// next-cycle implication, checked outside reset
`define SCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfd assertion failed");

`endif

// ----- design/scfd_pkg.sv -----
// shared types and constants of the serial command frame decoder
// no dependencies
`timescale 1ns / 1ps

package scfd_pkg;

    // frame characters
    localparam logic [7:0] CHAR_SOF  = 8'h3C;
    localparam logic [7:0] CHAR_SEP  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // frame position: index of the next frame character, idle outside a frame
    localparam logic [3:0] POS_IDLE  = 4'd0;
    localparam logic [3:0] POS_FIRST = 4'd1;
    localparam logic [3:0] POS_SEP   = 4'd4;
    localparam logic [3:0] POS_LAST  = 4'd8;

    // command codes
    localparam logic [9:0] CMD_START = 10'd1;
    localparam logic [9:0] CMD_STOP  = 10'd2;
    localparam logic [9:0] CMD_CLEAR = 10'd3;
    localparam logic [9:0] CMD_VSET  = 10'd14;
    localparam logic [9:0] CMD_ISET  = 10'd15;

    // plant states
    localparam logic [1:0] PLANT_OFF      = 2'd0;
    localparam logic [1:0] PLANT_STARTING = 2'd1;
    localparam logic [1:0] PLANT_ON       = 2'd2;
    localparam logic [1:0] PLANT_STOPPING = 2'd3;

    // voltage scale 9.34 as a fixed-point factor with 20 fraction bits, exact floor for 14-bit data
    localparam logic [23:0] VOLT_RECIP = 24'd9793700;
    localparam int          VOLT_SHIFT = 20;
    // current scale 98.5 as 197 / 2
    localparam logic [7:0]  CURR_SCALE = 8'd197;

    typedef struct packed {
        logic [7:0] rx_char;
        logic [1:0] plant_state;
    } rx_item_t;

    typedef struct packed {
        logic [9:0]  command_code;
        logic        frame_error;
        logic        state_request_valid;
        logic [1:0]  state_request;
        logic        fault_clear;
        logic        voltage_set_valid;
        logic [15:0] voltage_setpoint;
        logic        current_set_valid;
        logic [15:0] current_setpoint;
    } res_item_t;

    // a completed frame handed from the parser to the executor
    typedef struct packed {
        logic [9:0]  cmd;
        logic [13:0] data;
        logic        fault;
        logic [1:0]  plant;
    } frame_t;

endpackage

// ----- design/serial_command_frame_decoder_unit.sv -----
// Serial command frame decoder: takes received characters, one per item, and
// recognizes frames <ccc-dddd>; a '<' restarts a frame anywhere.
// rx channel (rx_valid/rx_ready/rx_item): one character plus the plant state.
// res channel (res_valid/res_ready/res_item): one result per completed frame,
// issued for the ninth frame character; other characters give no result.
// cfg channel (cfg_valid/cfg_ready/cfg_data): voltage offset, always ready.
// Throughput: one character per cycle while rx_ready is high; the frame register
// and the result register are two stages that a result passes through in order.
// rx_ready drops only while both stages hold items and res_ready is low;
// a waiting result does not stop characters from entering the frame stage.
// Reset clears the frame position, accumulators, offset and both setpoints.
// Depends on scfd_pkg, scfd_parser and scfd_exec.
`timescale 1ns / 1ps

module serial_command_frame_decoder_unit
    import scfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  rx_item_t    rx_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic   frm_valid;
    logic   frm_ready;
    frame_t frm;

    scfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    scfd_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

// ----- design/scfd_parser.sv -----
// character parser: tracks the frame position and accumulates digits
// depends on scfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "serial_command_frame_decoder_unit_assert.svh"

module scfd_parser
    import scfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rx_valid,
    output logic     rx_ready,
    input  rx_item_t rx_item,
    output logic     frm_valid,
    input  logic     frm_ready,
    output frame_t   frm
);

    logic [3:0]  pos_reg, pos_next;
    logic [9:0]  cmd_reg, cmd_next;
    logic [13:0] data_reg, data_next;
    logic        sep_reg, sep_next;
    logic        fault_reg, fault_next;
    logic        frm_valid_reg, frm_valid_next;
    frame_t      frm_reg, frm_next;
    logic        frm_load;
    logic        accept;
    logic        is_digit;
    logic [3:0]  dig;
    logic [13:0] cmd_mac;
    logic [17:0] data_mac;

    assign rx_ready  = !frm_valid_reg || frm_ready;
    assign accept    = rx_valid && rx_ready;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    assign is_digit = (rx_item.rx_char >= CHAR_ZERO) && (rx_item.rx_char <= CHAR_NINE);
    assign dig      = is_digit ? 4'(rx_item.rx_char - CHAR_ZERO) : 4'd0;

    // times ten as shift and add
    assign cmd_mac  = 14'({cmd_reg, 3'b000}) + 14'({cmd_reg, 1'b0}) + 14'(dig);
    assign data_mac = 18'({data_reg, 3'b000}) + 18'({data_reg, 1'b0}) + 18'(dig);

    always_comb
    begin
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        sep_next   = sep_reg;
        fault_next = fault_reg;
        frm_next   = frm_reg;
        frm_load   = 1'b0;
        if (accept)
        begin
            if (rx_item.rx_char == CHAR_SOF)
            begin
                pos_next   = POS_FIRST;
                cmd_next   = '0;
                data_next  = '0;
                sep_next   = 1'b0;
                fault_next = 1'b0;
            end
            else if (pos_reg == POS_IDLE || pos_reg > POS_LAST)
            begin
                pos_next = POS_IDLE;
            end
            else
            begin
                if (pos_reg == POS_SEP)
                begin
                    sep_next = (rx_item.rx_char == CHAR_SEP);
                end
                else
                begin
                    if (!is_digit)
                    begin
                        fault_next = 1'b1;
                    end
                    if (pos_reg < POS_SEP)
                    begin
                        cmd_next = cmd_mac[9:0];
                    end
                    else
                    begin
                        data_next = data_mac[13:0];
                    end
                end
                if (pos_reg < POS_LAST)
                begin
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    // last data digit: hand the frame on and go idle
                    frm_load       = 1'b1;
                    frm_next.cmd   = cmd_reg;
                    frm_next.data  = sep_reg ? data_mac[13:0] : 14'd0;
                    frm_next.fault = fault_reg || !is_digit;
                    frm_next.plant = rx_item.plant_state;
                    pos_next       = POS_IDLE;
                    cmd_next       = '0;
                    data_next      = '0;
                    sep_next       = 1'b0;
                    fault_next     = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (frm_load)
        begin
            frm_valid_next = 1'b1;
        end
        else if (frm_ready)
        begin
            frm_valid_next = 1'b0;
        end
        else
        begin
            frm_valid_next = frm_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            cmd_reg       <= '0;
            data_reg      <= '0;
            sep_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cmd_reg       <= cmd_next;
            data_reg      <= data_next;
            sep_reg       <= sep_next;
            fault_reg     <= fault_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frm_reg <= frm_next;
    end

    `SCFD_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg <= POS_LAST)
    `SCFD_ASSERT_NEXT(a_sof_restarts, accept && rx_item.rx_char == CHAR_SOF, pos_reg == POS_FIRST)
    `SCFD_ASSERT_NEXT(a_last_char_emits,
        accept && rx_item.rx_char != CHAR_SOF && pos_reg == POS_LAST,
        frm_valid_reg && pos_reg == POS_IDLE)

endmodule

// ----- design/scfd_exec.sv -----
// command executor: scales setpoints, acts on the command, holds the result register
// depends on scfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "serial_command_frame_decoder_unit_assert.svh"

module scfd_exec
    import scfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frm_valid,
    output logic        frm_ready,
    input  frame_t      frm,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item
);

    logic [15:0] offset_reg;
    logic [15:0] vstore_reg, vstore_next;
    logic [15:0] istore_reg, istore_next;
    logic        res_valid_reg, res_valid_next;
    res_item_t   res_reg, res_next;
    logic        take;
    logic [37:0] v_prod;
    logic [15:0] v_scaled;
    logic [21:0] i_prod;
    logic [20:0] i_half;
    logic [15:0] i_sat;

    assign cfg_ready = 1'b1;
    assign frm_ready = !res_valid_reg || res_ready;
    assign take      = frm_valid && frm_ready;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    assign v_prod   = 38'(frm.data) * 38'(VOLT_RECIP);
    assign v_scaled = v_prod[VOLT_SHIFT +: 16];
    assign i_prod   = 22'(frm.data) * 22'(CURR_SCALE);
    assign i_half   = i_prod[21:1];
    assign i_sat    = (|i_half[20:16]) ? 16'hFFFF : i_half[15:0];

    always_comb
    begin
        vstore_next = vstore_reg;
        istore_next = istore_reg;
        res_next    = '0;
        res_next.frame_error = frm.fault;
        if (!frm.fault)
        begin
            res_next.command_code = frm.cmd;
            unique case (frm.cmd)
                CMD_START:
                begin
                    if (frm.plant == PLANT_OFF)
                    begin
                        res_next.state_request_valid = 1'b1;
                        res_next.state_request       = PLANT_STARTING;
                    end
                end
                CMD_STOP:
                begin
                    if (frm.plant == PLANT_ON)
                    begin
                        res_next.state_request_valid = 1'b1;
                        res_next.state_request       = PLANT_STOPPING;
                    end
                end
                CMD_CLEAR:
                begin
                    res_next.fault_clear = 1'b1;
                end
                CMD_VSET:
                begin
                    vstore_next                = v_scaled - offset_reg;
                    res_next.voltage_set_valid = 1'b1;
                end
                CMD_ISET:
                begin
                    istore_next                = i_sat;
                    res_next.current_set_valid = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        res_next.voltage_setpoint = vstore_next;
        res_next.current_setpoint = istore_next;
    end

    always_comb
    begin
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            vstore_reg    <= '0;
            istore_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            if (take)
            begin
                vstore_reg <= vstore_next;
                istore_reg <= istore_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    `SCFD_ASSERT_NEXT(a_frame_lands, take, res_valid_reg)
    `SCFD_ASSERT_NOW(a_one_action, res_valid_reg,
        $onehot0({res_reg.state_request_valid, res_reg.fault_clear,
                  res_reg.voltage_set_valid, res_reg.current_set_valid}))
    `SCFD_ASSERT_NOW(a_error_quiet, res_valid_reg && res_reg.frame_error,
        res_reg.command_code == 10'd0 && !res_reg.state_request_valid &&
        !res_reg.fault_clear && !res_reg.voltage_set_valid && !res_reg.current_set_valid)
    `SCFD_ASSERT_NOW(a_request_code, res_valid_reg,
        res_reg.state_request_valid == (res_reg.state_request != 2'd0))

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for serial_command_frame_decoder_unit: feeds character streams,
// predicts each completed frame's result and compares it field by field
// depends on scfd_pkg and the decoder RTL
`timescale 1ns / 1ps

module testbench;
    import scfd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 5;
    localparam int CHARS_PER_PHASE = 150;
    localparam int VOLT_NUM     = 934;
    localparam int VOLT_DEN     = 100;
    localparam int CURR_DEN     = 2;
    localparam int NO_DAMAGE    = -1;
    localparam int FULL_FRAME   = 9;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    rx_item_t    rx_item = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    rx_item_t    pending_chars[$];
    res_item_t   expected_results[$];
    int          fail_count = 0;

    // mirror of the decoder state
    logic [3:0]  frame_pos = POS_IDLE;
    logic [9:0]  cmd_acc = '0;
    logic [13:0] data_acc = '0;
    logic        sep_seen = 1'b0;
    logic        digit_bad = 1'b0;
    logic [15:0] volt_store = '0;
    logic [15:0] curr_store = '0;
    logic [15:0] volt_offset = '0;

    serial_command_frame_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_frame_state();
        cmd_acc   = '0;
        data_acc  = '0;
        sep_seen  = 1'b0;
        digit_bad = 1'b0;
    endtask

    task automatic decode_character(input rx_item_t it);
        logic        is_digit;
        logic [3:0]  digit_val;
        logic [13:0] data_word;
        int unsigned scaled;
        res_item_t   r;
        is_digit  = (it.rx_char >= CHAR_ZERO) && (it.rx_char <= CHAR_NINE);
        digit_val = is_digit ? 4'(it.rx_char - CHAR_ZERO) : 4'd0;
        if (it.rx_char == CHAR_SOF)
        begin
            frame_pos = POS_FIRST;
            clear_frame_state();
        end
        else if (frame_pos == POS_IDLE || frame_pos > POS_LAST)
        begin
            frame_pos = POS_IDLE;
        end
        else
        begin
            if (frame_pos == POS_SEP)
                sep_seen = (it.rx_char == CHAR_SEP);
            else
            begin
                if (!is_digit)
                    digit_bad = 1'b1;
                if (frame_pos < POS_SEP)
                    cmd_acc = 10'(cmd_acc * 10 + digit_val);
                else
                    data_acc = 14'(data_acc * 10 + digit_val);
            end
            if (frame_pos < POS_LAST)
                frame_pos = frame_pos + 4'd1;
            else
            begin
                // ninth character: the frame completes and gives one result
                frame_pos = POS_IDLE;
                data_word = sep_seen ? data_acc : 14'd0;
                r = '0;
                r.frame_error = digit_bad;
                if (!digit_bad)
                begin
                    r.command_code = cmd_acc;
                    case (cmd_acc)
                        CMD_START:
                            if (it.plant_state == PLANT_OFF)
                            begin
                                r.state_request_valid = 1'b1;
                                r.state_request       = PLANT_STARTING;
                            end
                        CMD_STOP:
                            if (it.plant_state == PLANT_ON)
                            begin
                                r.state_request_valid = 1'b1;
                                r.state_request       = PLANT_STOPPING;
                            end
                        CMD_CLEAR:
                            r.fault_clear = 1'b1;
                        CMD_VSET:
                        begin
                            scaled = (32'(data_word) * VOLT_NUM) / VOLT_DEN;
                            volt_store = 16'(scaled) - volt_offset;
                            r.voltage_set_valid = 1'b1;
                        end
                        CMD_ISET:
                        begin
                            scaled = (32'(data_word) * CURR_SCALE) / CURR_DEN;
                            curr_store = (scaled > 32'hFFFF) ? 16'hFFFF : 16'(scaled);
                            r.current_set_valid = 1'b1;
                        end
                        default: ;
                    endcase
                end
                r.voltage_setpoint = volt_store;
                r.current_setpoint = curr_store;
                expected_results.push_back(r);
                clear_frame_state();
            end
        end
    endtask

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
                decode_character(rx_item);
            if (!rx_valid || rx_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    rx_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    rx_item  <= pending_chars.pop_front();
                    rx_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // receiver stalls follow a rotating pattern that is redrawn now and then
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
                default: stall_pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        pattern_age = pattern_age - 1;
        res_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    res_item_t want;
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none actual command_code %0d",
                         $time, res_item.command_code);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("command_code", 16'(want.command_code),
                            16'(res_item.command_code));
                check_field("frame_error", 16'(want.frame_error), 16'(res_item.frame_error));
                check_field("state_request_valid", 16'(want.state_request_valid),
                            16'(res_item.state_request_valid));
                check_field("state_request", 16'(want.state_request),
                            16'(res_item.state_request));
                check_field("fault_clear", 16'(want.fault_clear), 16'(res_item.fault_clear));
                check_field("voltage_set_valid", 16'(want.voltage_set_valid),
                            16'(res_item.voltage_set_valid));
                check_field("voltage_setpoint", want.voltage_setpoint, res_item.voltage_setpoint);
                check_field("current_set_valid", 16'(want.current_set_valid),
                            16'(res_item.current_set_valid));
                check_field("current_setpoint", want.current_setpoint, res_item.current_setpoint);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_char(input logic [7:0] ch, input logic [1:0] plant);
        rx_item_t it;
        it.rx_char     = ch;
        it.plant_state = plant;
        pending_chars.push_back(it);
    endtask

    // frame <ccc-dddd>, optionally with one damaged character and cut short
    task automatic push_frame(input int cmd, input int data, input logic [1:0] plant,
                              input int bad_pos, input logic [7:0] bad_char,
                              input int length);
        logic [7:0] chars[9];
        chars[0] = CHAR_SOF;
        chars[1] = CHAR_ZERO + 8'((cmd / 100) % 10);
        chars[2] = CHAR_ZERO + 8'((cmd / 10) % 10);
        chars[3] = CHAR_ZERO + 8'(cmd % 10);
        chars[4] = CHAR_SEP;
        chars[5] = CHAR_ZERO + 8'((data / 1000) % 10);
        chars[6] = CHAR_ZERO + 8'((data / 100) % 10);
        chars[7] = CHAR_ZERO + 8'((data / 10) % 10);
        chars[8] = CHAR_ZERO + 8'(data % 10);
        if (bad_pos >= 0)
            chars[bad_pos] = bad_char;
        for (int i = 0; i < length; i++)
            push_char(chars[i], (i == 8) ? plant : 2'($urandom_range(0, 3)));
    endtask

    function automatic int pick_cmd();
        case ($urandom_range(0, 9))
            0: return CMD_START;
            1: return CMD_STOP;
            2: return CMD_CLEAR;
            3, 4: return CMD_VSET;
            5, 6: return CMD_ISET;
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic int pick_data();
        int edges[8] = '{0, 9999, 665, 666, 7016, 7017, 1, 9998};
        if ($urandom_range(0, 4) == 0)
            return edges[$urandom_range(0, 7)];
        return $urandom_range(0, 9999);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] near[6] = '{8'h2F, 8'h3A, CHAR_SOF, CHAR_SEP, CHAR_ZERO, CHAR_NINE};
        if ($urandom_range(0, 1) == 0)
            return near[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_random_traffic(input int count);
        int made;
        int kind;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                push_frame(pick_cmd(), pick_data(), 2'($urandom_range(0, 3)),
                           NO_DAMAGE, 8'h00, FULL_FRAME);
                made += FULL_FRAME;
            end
            else if (kind < 78)
            begin
                push_frame(pick_cmd(), pick_data(), 2'($urandom_range(0, 3)),
                           $urandom_range(1, 8), pick_bad_char(), FULL_FRAME);
                made += FULL_FRAME;
            end
            else if (kind < 88)
            begin
                // cut short; whatever follows lands inside the open frame
                kind = $urandom_range(1, 8);
                push_frame(pick_cmd(), pick_data(), 2'($urandom_range(0, 3)),
                           NO_DAMAGE, 8'h00, kind);
                made += kind;
            end
            else
            begin
                kind = $urandom_range(1, 4);
                repeat (kind)
                    push_char(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
                made += kind;
            end
        end
    endtask

    task automatic push_directed();
        // stray characters outside any frame
        push_char("A", PLANT_OFF);
        push_char(8'hFF, PLANT_STOPPING);
        push_char(CHAR_SEP, PLANT_ON);
        push_frame(CMD_START, 0, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_START, 0, PLANT_ON, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_STOP, 0, PLANT_ON, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_STOP, 0, PLANT_STOPPING, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_CLEAR, 0, PLANT_STARTING, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_VSET, 9999, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_VSET, 0, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_ISET, 9999, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(CMD_ISET, 665, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        // missing separator forces data to zero
        push_frame(CMD_VSET, 1234, PLANT_OFF, 4, "+", FULL_FRAME);
        // non-digit in command and in data positions
        push_frame(CMD_CLEAR, 0, PLANT_OFF, 2, "a", FULL_FRAME);
        push_frame(CMD_ISET, 4321, PLANT_OFF, 7, 8'h3A, FULL_FRAME);
        // restart in the middle of a frame
        push_frame(CMD_START, 0, PLANT_OFF, NO_DAMAGE, 8'h00, 3);
        push_frame(CMD_CLEAR, 0, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(999, 9999, PLANT_ON, NO_DAMAGE, 8'h00, FULL_FRAME);
        push_frame(0, 0, PLANT_OFF, NO_DAMAGE, 8'h00, FULL_FRAME);
    endtask

    // returns just after a rising edge once everything has drained
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || rx_valid || expected_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        volt_offset = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] offset_val;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase_idx = 0; phase_idx < PHASES; phase_idx++)
        begin
            wait_for_idle();
            case (phase_idx)
                0: offset_val = 16'h0000;
                1: offset_val = 16'hFFFF;
                3: offset_val = 16'h0001;
                default: offset_val = 16'($urandom);
            endcase
            write_offset(offset_val);
            @(negedge clk);
            if (phase_idx == 0)
                push_directed();
            push_random_traffic(CHARS_PER_PHASE);
        end
        wait_for_idle();
        @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/scfd_pkg.sv
design/scfd_parser.sv
design/scfd_exec.sv
design/serial_command_frame_decoder_unit.sv
sim/testbench.sv
